### design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### design/sss_pkg.sv
`default_nettype none

package sss_pkg;

    localparam int MAX_PATTERN_DEF = 64;
    localparam int CNT_W           = 32;
    localparam int ADDR_W          = 48;
    localparam int LEN_REG_W       = 7;
    localparam int IDX_W           = 6;
    localparam int DATA_W          = 8;
    localparam int APB_DATA_W      = 64;
    localparam int APB_ADDR_W      = 4;

    localparam logic REQ_PATTERN  = 1'b0;
    localparam logic REQ_HAYSTACK = 1'b1;

    localparam logic REG_PATTERN_LENGTH = 1'b0;
    localparam logic REG_SEARCH_BASE    = 1'b1;

    typedef struct packed {
        logic              shift;
        logic [DATA_W-1:0] data;
    } cell_ctrl_t;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] offset;
    } result_t;

endpackage

`default_nettype wire

### design/sss_cell.sv
`default_nettype none

module sss_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  sss_pkg::cell_ctrl_t  ctrl,
    input  wire                  load,
    input  wire                  prev_match,
    output logic                 match_now,
    output logic                 match_reg
);

    logic [sss_pkg::DATA_W-1:0] pat_reg;
    logic [sss_pkg::DATA_W-1:0] pat_next;
    logic                       match_next;

    // The cell matches when the prefix ending in its left neighbor matched
    // one byte earlier and the new byte equals this cell's pattern byte.
    assign match_now  = prev_match && (ctrl.data == pat_reg);
    assign pat_next   = load ? ctrl.data : pat_reg;
    assign match_next = ctrl.shift ? match_now : match_reg;

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

endmodule

`default_nettype wire

### design/sss_result.sv
`default_nettype none

module sss_result (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               load,
    input  sss_pkg::result_t                  load_data,
    input  wire  [sss_pkg::ADDR_W-1:0]        base,
    output logic                              space,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic                              found,
    output logic [sss_pkg::ADDR_W-1:0]        match_address
);

    localparam int AW = sss_pkg::ADDR_W;

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    sss_pkg::result_t        s1_data_reg;
    sss_pkg::result_t        s1_data_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    out_found_reg;
    logic                    out_found_next;
    logic [AW-1:0]           out_addr_reg;
    logic [AW-1:0]           out_addr_next;
    logic                    out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign space    = !s1_valid_reg || out_free;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_data_next  = s1_data_reg;
        if (load)
        begin
            s1_valid_next = 1'b1;
            s1_data_next  = load_data;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_addr_next  = out_addr_reg;
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
            out_found_next = s1_data_reg.found;
            out_addr_next  = s1_data_reg.found ? (base + AW'(s1_data_reg.offset)) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_data_reg   <= s1_data_next;
        out_found_reg <= out_found_next;
        out_addr_reg  <= out_addr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = out_found_reg;
    assign match_address = out_addr_reg;

endmodule

`default_nettype wire

### design/stream_substring_search.sv
// Streaming exact substring search. Load the pattern with one request per byte
// (each load also restarts the search), set pattern_length and search_base over
// the APB port, then stream haystack bytes. The block takes one request in every
// clock cycle and reports the first match, or a not-found result on the byte
// marked last, through the result path's s1 and output registers. Matching is
// done by a row of MAX_PATTERN cells, one per pattern byte, each keeping a
// prefix-match flag that passes to its neighbor as every byte arrives, so the
// rate does not depend on the pattern length. Requests stall only while the
// output is held back by out_ready and the two-entry result path is full.
// Registers sit at byte addresses 0 (pattern_length) and 8 (search_base).
`default_nettype none

module stream_substring_search #(
    parameter int MAX_PATTERN = sss_pkg::MAX_PATTERN_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [sss_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire  [sss_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [sss_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire                                  req_type,
    input  wire  [sss_pkg::IDX_W-1:0]            pattern_index,
    input  wire  [sss_pkg::DATA_W-1:0]           data_byte,
    input  wire                                  last,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic                                 found,
    output logic [sss_pkg::ADDR_W-1:0]           match_address
);

    localparam int CW = sss_pkg::CNT_W;
    localparam int AW = sss_pkg::ADDR_W;
    localparam int DW = sss_pkg::APB_DATA_W;
    localparam int RW = sss_pkg::LEN_REG_W;
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [RW-1:0]          pattern_length_reg;
    logic [RW-1:0]          pattern_length_next;
    logic [AW-1:0]          search_base_reg;
    logic [AW-1:0]          search_base_next;
    logic [CW-1:0]          cnt_reg;
    logic [CW-1:0]          cnt_next;
    logic                   finished_reg;
    logic                   finished_next;

    logic                   cfg_write;
    logic                   reg_idx;
    logic                   accept;
    logic                   pat_accept;
    logic                   step;
    logic                   space;
    logic                   len_sat;
    logic [LW-1:0]          len_eff;
    logic [LW-1:0]          len_m1;
    logic [IW-1:0]          sel;
    logic [CW-1:0]          len_cnt;
    logic                   cnt_sat;
    logic [CW-1:0]          cnt_inc;
    logic [CW-1:0]          offset;
    logic                   hit;
    logic                   res_load;
    sss_pkg::result_t       res;
    sss_pkg::cell_ctrl_t    ctrl;
    logic [MAX_PATTERN-1:0] match_now;
    logic [MAX_PATTERN-1:0] match_reg;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[3];

    always_comb
    begin
        pattern_length_next = pattern_length_reg;
        search_base_next    = search_base_reg;
        if (cfg_write)
        begin
            unique case (reg_idx)
                sss_pkg::REG_PATTERN_LENGTH: pattern_length_next = pwdata[RW-1:0];
                sss_pkg::REG_SEARCH_BASE:    search_base_next    = pwdata[AW-1:0];
                default:                     pattern_length_next = pattern_length_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            sss_pkg::REG_PATTERN_LENGTH: prdata = DW'(pattern_length_reg);
            sss_pkg::REG_SEARCH_BASE:    prdata = DW'(search_base_reg);
            default:                     prdata = '0;
        endcase
    end

    // Request decode.
    assign accept     = in_valid && in_ready;
    assign in_ready   = space;
    assign pat_accept = accept && (req_type == sss_pkg::REQ_PATTERN);
    assign step       = accept && (req_type == sss_pkg::REQ_HAYSTACK) && !finished_reg;

    assign ctrl.shift = step;
    assign ctrl.data  = data_byte;

    // Cell row.
    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            logic prev;
            logic load;
            if (k == 0)
            begin : g_first
                assign prev = 1'b1;
            end
            else
            begin : g_rest
                assign prev = match_reg[k-1];
            end
            assign load = pat_accept && (CW'(pattern_index) == CW'(k));
            sss_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .load       (load),
                .prev_match (prev),
                .match_now  (match_now[k]),
                .match_reg  (match_reg[k])
            );
        end
    endgenerate

    // Match decision.
    assign len_sat = CW'(pattern_length_reg) > CW'(MAX_PATTERN);
    assign len_eff = len_sat ? LW'(MAX_PATTERN) : LW'(pattern_length_reg);
    assign len_m1  = len_eff - LW'(1);
    assign sel     = len_m1[IW-1:0];
    assign len_cnt = CW'(len_eff);
    assign cnt_sat = &cnt_reg;
    assign cnt_inc = cnt_sat ? cnt_reg : (cnt_reg + CW'(1));
    assign offset  = (len_eff == '0) ? '0 : (cnt_inc - len_cnt);
    assign hit     = (len_eff == '0) || ((cnt_inc >= len_cnt) && match_now[sel]);

    assign res_load   = step && (hit || last);
    assign res.found  = hit;
    assign res.offset = hit ? offset : '0;

    always_comb
    begin
        cnt_next      = cnt_reg;
        finished_next = finished_reg;
        if (pat_accept)
        begin
            cnt_next      = '0;
            finished_next = 1'b0;
        end
        else if (accept)
        begin
            if (finished_reg)
            begin
                if (last)
                begin
                    cnt_next      = '0;
                    finished_next = 1'b0;
                end
            end
            else if (last)
            begin
                cnt_next      = '0;
                finished_next = 1'b0;
            end
            else
            begin
                cnt_next      = cnt_inc;
                finished_next = hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            search_base_reg    <= '0;
            cnt_reg            <= '0;
            finished_reg       <= 1'b0;
        end
        else
        begin
            pattern_length_reg <= pattern_length_next;
            search_base_reg    <= search_base_next;
            cnt_reg            <= cnt_next;
            finished_reg       <= finished_next;
        end
    end

    sss_result u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (res_load),
        .load_data     (res),
        .base          (search_base_reg),
        .space         (space),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .match_address (match_address)
    );

`include "assert_macros.svh"

    `ASSERT_IMPLY(a_load_clears, clk, rst_n, pat_accept |=> (cnt_reg == '0) && !finished_reg)
    `ASSERT_IMPLY(a_hit_finishes, clk, rst_n, (step && hit && !last) |=> finished_reg)
    `ASSERT_NEVER(a_stall_cause, clk, rst_n, !in_ready && !(out_valid && !out_ready))

endmodule

`default_nettype wire
